FILE: rtl/cnlbc_pkg.sv
package cnlbc_pkg;

	localparam int NUM_BITS   = 63;   // card number width
	localparam int NUM_DIGITS = 19;   // decimal digits of a 63-bit value
	localparam int DIGIT_W    = 4;
	localparam int BIT_CNT_W  = 6;    // counts the NUM_BITS conversion steps
	localparam int DIG_CNT_W  = 5;    // digit position, also digit count 0..19
	localparam int IN_W       = 64;
	localparam int OUT_W      = 16;

	typedef logic [DIGIT_W-1:0]   digit_t;
	typedef logic [DIG_CNT_W-1:0] dig_cnt_t;
	typedef logic [1:0]           class_t;

	localparam class_t CLS_NONE  = 2'd0;
	localparam class_t CLS_34_37 = 2'd1;
	localparam class_t CLS_51_55 = 2'd2;
	localparam class_t CLS_4X    = 2'd3;

	// digit cell controls, priority clr > conv > shift
	typedef struct packed {
		logic clr;
		logic conv;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic clr;
		logic step;
	} scan_ctrl_t;

	typedef struct packed {
		digit_t   lead;
		digit_t   second;
		dig_cnt_t count;
		logic     luhn_ok;
	} scan_res_t;

	function automatic class_t classify(digit_t lead, digit_t second, dig_cnt_t count);
		class_t c;
		c = CLS_NONE;
		if (lead == 4'd3 && (second == 4'd4 || second == 4'd7) && count == 5'd15)
			c = CLS_34_37;
		else if (lead == 4'd5 && second >= 4'd1 && second <= 4'd5 && count == 5'd16)
			c = CLS_51_55;
		else if (lead == 4'd4 && (count == 5'd13 || count == 5'd16))
			c = CLS_4X;
		return c;
	endfunction

endpackage

FILE: rtl/cnlbc_cell.sv
module cnlbc_cell (
	input  logic                  clk,
	input  cnlbc_pkg::cell_ctrl_t ctrl,
	input  logic                  bit_in,    // from lower neighbor (conversion)
	input  cnlbc_pkg::digit_t     digit_in,  // from upper neighbor (scan)
	output logic                  bit_out,
	output cnlbc_pkg::digit_t     digit
);
	import cnlbc_pkg::*;

	digit_t digit_q;
	digit_t adj;

	// add-3 correction before the left shift
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

FILE: rtl/cnlbc_scan.sv
module cnlbc_scan (
	input  logic                  clk,
	input  cnlbc_pkg::scan_ctrl_t ctrl,
	input  cnlbc_pkg::digit_t     digit,  // current least significant digit
	input  cnlbc_pkg::dig_cnt_t   pos,    // its position from the right
	output cnlbc_pkg::scan_res_t  res
);
	import cnlbc_pkg::*;

	digit_t   sum_q;     // Luhn sum mod 10
	digit_t   prev_q;
	digit_t   lead_q;
	digit_t   second_q;
	dig_cnt_t count_q;

	logic [4:0] dbl;
	digit_t     term;
	logic [4:0] acc;

	assign dbl  = {digit, 1'b0};
	assign term = pos[0] ? ((dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0]) : digit;
	assign acc  = {1'b0, sum_q} + {1'b0, term};

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			sum_q    <= '0;
			prev_q   <= '0;
			lead_q   <= '0;
			second_q <= '0;
			count_q  <= '0;
		end else if (ctrl.step) begin
			sum_q  <= (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
			prev_q <= digit;
			if (digit != '0) begin
				lead_q   <= digit;
				second_q <= prev_q;
				count_q  <= pos + 5'd1;
			end
		end
	end

	assign res.lead    = lead_q;
	assign res.second  = second_q;
	assign res.count   = count_q;
	assign res.luhn_ok = (sum_q == '0);

endmodule

FILE: rtl/card_number_luhn_brand_check.sv
// Card number check: Luhn mod-10 test plus a prefix/length class.
//
// Input channel (s_*): one item carries card_number, an unsigned 63-bit
// integer in s_tdata[62:0]. Output channel (m_*): one result item per input
// item with card_class, luhn_ok, prefix_class and digit_count.
//
// Sequence: one item at a time. After acceptance the number is shifted MSB
// first into a row of 19 BCD digit cells (shift-and-add-3). The same row
// then shifts one digit per cycle toward cell 0, where the scan unit forms
// the Luhn sum, digit count and leading two digits. The output register is
// then loaded, and a new item is taken the cycle after the result is loaded.
//
// Reset (arst_n low) empties the block: no result pending, s_tready high.
// A stalled receiver holds the result in the output register; a next item
// can still be accepted and converted, and it waits at the end until the
// output register is free.
module card_number_luhn_brand_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [cnlbc_pkg::IN_W-1:0] s_tdata,  // [62:0] card_number, [63] zero
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cnlbc_pkg::OUT_W-1:0] m_tdata  // [1:0] card_class, [2] luhn_ok,
	                                             // [4:3] prefix_class,
	                                             // [9:5] digit_count, [15:10] zero
);
	import cnlbc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(NUM_BITS - 1);
	localparam dig_cnt_t             DIG_LAST = DIG_CNT_W'(NUM_DIGITS - 1);

	state_t                 state_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	dig_cnt_t               dig_cnt_q;
	logic [NUM_BITS-1:0]    card_q;     // binary operand, shifted out MSB first

	logic                   s_acc;
	logic                   out_free;
	cell_ctrl_t             cell_ctrl;
	scan_ctrl_t             scan_ctrl;
	scan_res_t              scan_res;
	logic [NUM_DIGITS-1:0]  bit_chain;
	digit_t                 digits [NUM_DIGITS];
	class_t                 pclass;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign cell_ctrl.clr   = s_acc;
	assign cell_ctrl.conv  = (state_q == ST_CONV);
	assign cell_ctrl.shift = (state_q == ST_SCAN);
	assign scan_ctrl.clr   = s_acc;
	assign scan_ctrl.step  = (state_q == ST_SCAN);

	// row of BCD digit cells; cell 0 is the least significant digit
	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
		logic   bin;
		digit_t din;
		if (k == 0) begin : g_lo
			assign bin = card_q[NUM_BITS-1];
		end else begin : g_mid
			assign bin = bit_chain[k-1];
		end
		if (k == NUM_DIGITS - 1) begin : g_hi
			assign din = '0;
		end else begin : g_up
			assign din = digits[k+1];
		end
		cnlbc_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.bit_in   (bin),
			.digit_in (din),
			.bit_out  (bit_chain[k]),
			.digit    (digits[k])
		);
	end

	// Luhn sum, digit count and leading digits from the digit stream
	cnlbc_scan u_scan (
		.clk   (clk),
		.ctrl  (scan_ctrl),
		.digit (digits[0]),
		.pos   (dig_cnt_q),
		.res   (scan_res)
	);

	assign pclass = classify(scan_res.lead, scan_res.second, scan_res.count);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			card_q <= s_tdata[NUM_BITS-1:0];
		end else if (state_q == ST_CONV) begin
			card_q <= {card_q[NUM_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BIT_LAST) begin
						state_q   <= ST_SCAN;
						dig_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					dig_cnt_q <= dig_cnt_q + 1'b1;
					if (dig_cnt_q == DIG_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= {6'b0, scan_res.count, pclass, scan_res.luhn_ok,
				(scan_res.luhn_ok ? pclass : CLS_NONE)};
		end
	end

	// an accepted item always starts a fresh conversion
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q == ST_CONV && bit_cnt_q == '0))
		else $error("conversion did not start after accept");

	// a class is reported only with a passing checksum and equals the prefix class
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == CLS_NONE ||
			(m_tdata[2] && m_tdata[1:0] == m_tdata[4:3])))
		else $error("card_class inconsistent with luhn_ok/prefix_class");

	// a 63-bit value has at most 19 digits
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:5] <= 5'd19))
		else $error("digit_count out of range");

	// the scan phase begins only after the last conversion step
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SCAN) |-> $past(bit_cnt_q) == BIT_LAST)
		else $error("scan began before conversion finished");

endmodule
